@@ hw/rtl/telnet_iac_filter_negotiator_macros.svh @@
// Assertion macros for the telnet IAC filter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TELNET_IAC_FILTER_NEGOTIATOR_MACROS_SVH
`define TELNET_IAC_FILTER_NEGOTIATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TIFN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define TIFN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

@@ hw/rtl/tifn_pkg.sv @@
// Types and constants for the telnet IAC filter and option negotiator.
// No dependencies.
package tifn_pkg;

   localparam logic [7:0] T_IAC  = 8'd255;
   localparam logic [7:0] T_WILL = 8'd251;
   localparam logic [7:0] T_WONT = 8'd252;
   localparam logic [7:0] T_DO   = 8'd253;
   localparam logic [7:0] T_DONT = 8'd254;
   localparam logic [7:0] T_SB   = 8'd250;
   localparam logic [7:0] T_SE   = 8'd240;

   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_IAC    = 3'd1,
      ST_OPTION = 3'd2,
      ST_SUB    = 3'd3,
      ST_SUBIAC = 3'd4
   } parse_state_type;

endpackage

@@ hw/rtl/telnet_iac_filter_negotiator.sv @@
// Telnet receive filter and option negotiator; uses tifn_pkg and the macros header.
// Path: an accepted input word passes the input register, then the result register, to rsp_tvalid.
// Throughput: one word per cycle while rsp_tready keeps the result register free; the
// parser state updates once per word as it leaves the input register.
// Reset (synchronous, active high): parser in data state, pending verb zero, both
// stages empty.
`include "telnet_iac_filter_negotiator_macros.svh"

module telnet_iac_filter_negotiator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [15:8] reply_verb, [23:16] reply_option
   output logic [0:0]  rsp_tuser    // [0] out_kind
);
   import tifn_pkg::*;

   parse_state_type state_ff, state_in;
   logic [7:0]      verb_ff, verb_in;
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   logic            out_kind_ff;
   logic [23:0]     out_data_ff;

   logic            advance;
   logic            emit;
   logic            kind;
   logic [7:0]      data_byte;
   logic [7:0]      reply_verb;
   logic [7:0]      reply_option;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // parser: next state and result word
   always_comb begin
      state_in     = state_ff;
      verb_in      = verb_ff;
      emit         = 1'b0;
      kind         = KIND_DATA;
      data_byte    = 8'd0;
      reply_verb   = 8'd0;
      reply_option = 8'd0;
      if (advance) begin
         case (state_ff)
            ST_IAC: begin
               if (in_byte_ff == T_IAC) begin
                  state_in  = ST_DATA;
                  emit      = 1'b1;
                  data_byte = T_IAC;
               end else if (in_byte_ff inside {[T_WILL:T_DONT]}) begin
                  verb_in  = in_byte_ff;
                  state_in = ST_OPTION;
               end else if (in_byte_ff == T_SB) begin
                  state_in = ST_SUB;
               end else begin
                  state_in = ST_DATA;
               end
            end
            ST_OPTION: begin
               state_in     = ST_DATA;
               emit         = 1'b1;
               kind         = KIND_REPLY;
               reply_option = in_byte_ff;
               if (verb_ff == T_WILL) begin
                  reply_verb = (in_byte_ff inside {OPT_ECHO, OPT_SGA}) ? T_DO : T_DONT;
               end else if (verb_ff == T_DO) begin
                  reply_verb = (in_byte_ff == OPT_SGA) ? T_WILL : T_WONT;
               end else if (verb_ff == T_WONT) begin
                  reply_verb = T_DONT;
               end else begin
                  reply_verb = T_WONT;
               end
            end
            ST_SUB: begin
               if (in_byte_ff == T_IAC) begin
                  state_in = ST_SUBIAC;
               end
            end
            ST_SUBIAC: begin
               state_in = (in_byte_ff == T_SE) ? ST_DATA : ST_SUB;
            end
            default: begin
               if (in_byte_ff == T_IAC) begin
                  state_in = ST_IAC;
               end else begin
                  state_in  = ST_DATA;
                  emit      = 1'b1;
                  data_byte = in_byte_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
         verb_ff  <= 8'd0;
      end else begin
         state_ff <= state_in;
         verb_ff  <= verb_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_kind_ff <= kind;
         out_data_ff <= {reply_option, reply_verb, data_byte};
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_kind_ff;

   `TIFN_ASSERT_NOW(a_option_has_verb, clock, reset, state_ff == ST_OPTION,
      verb_ff == T_WILL || verb_ff == T_WONT || verb_ff == T_DO || verb_ff == T_DONT)
   `TIFN_ASSERT_NOW(a_reply_fields, clock, reset, rsp_tvalid && rsp_tuser[0] == KIND_REPLY,
      rsp_tdata[7:0] == 8'd0 && rsp_tdata[15:8] >= T_WILL && rsp_tdata[15:8] <= T_DONT)
   `TIFN_ASSERT_NOW(a_data_fields, clock, reset, rsp_tvalid && rsp_tuser[0] == KIND_DATA,
      rsp_tdata[23:8] == 16'd0)
   `TIFN_ASSERT_NEXT(a_input_hold, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_byte_ff) && $stable(state_ff))

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for telnet_iac_filter_negotiator: byte stream in, data/reply words out.
// Predicts the IAC parser and reply policy in-bench; depends on tifn_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_top;
   import tifn_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int N_RANDOM     = 600;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] verb;
      logic [7:0] opt;
   } out_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // [7:0] data_byte, [15:8] reply_verb, [23:16] reply_option
   logic [0:0]  rsp_tuser;   // [0] out_kind

   out_word_type    out_q[$];
   parse_state_type mdl_state;
   logic [7:0]      mdl_verb;
   int              mismatch_cnt = 0;
   int              sent_cnt = 0;
   int              cycle_cnt = 0;
   int              hold_len = 0;
   bit              idle_on = 1'b1;

   telnet_iac_filter_negotiator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, out_q.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic logic [7:0] reply_for(logic [7:0] verb, logic [7:0] opt);
      if (verb == T_WILL)
         return (opt == OPT_ECHO || opt == OPT_SGA) ? T_DO : T_DONT;
      if (verb == T_DO)
         return (opt == OPT_SGA) ? T_WILL : T_WONT;
      if (verb == T_WONT)
         return T_DONT;
      return T_WONT;
   endfunction

   task automatic parse_rx_byte(logic [7:0] b);
      out_word_type w;
      w = '0;
      case (mdl_state)
         ST_IAC: begin
            if (b == T_IAC) begin
               mdl_state = ST_DATA;
               w.kind = KIND_DATA;
               w.data = T_IAC;
               out_q.push_back(w);
            end else if (b >= T_WILL && b <= T_DONT) begin
               mdl_verb  = b;
               mdl_state = ST_OPTION;
            end else if (b == T_SB) begin
               mdl_state = ST_SUB;
            end else begin
               mdl_state = ST_DATA;
            end
         end
         ST_OPTION: begin
            mdl_state = ST_DATA;
            w.kind = KIND_REPLY;
            w.verb = reply_for(mdl_verb, b);
            w.opt  = b;
            out_q.push_back(w);
         end
         ST_SUB: begin
            if (b == T_IAC)
               mdl_state = ST_SUBIAC;
         end
         ST_SUBIAC: begin
            mdl_state = (b == T_SE) ? ST_DATA : ST_SUB;
         end
         default: begin
            if (b == T_IAC) begin
               mdl_state = ST_IAC;
            end else begin
               mdl_state = ST_DATA;
               w.kind = KIND_DATA;
               w.data = b;
               out_q.push_back(w);
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls plus a long hold-off on request
   initial begin : rsp_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            stall = hold_len;
            hold_len = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (idle_on && !reset && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            stall = pick_gap() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      out_word_type got;
      out_word_type want;
      got = {rsp_tuser[0], rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (out_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected word: kind %0d data %0d verb %0d opt %0d",
                        got.kind, got.data, got.verb, got.opt);
         end else begin
            want = out_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data ||
                got.verb !== want.verb || got.opt !== want.opt) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: exp kind %0d data %0d verb %0d opt %0d",
                           want.kind, want.data, want.verb, want.opt,
                           ", got kind %0d data %0d verb %0d opt %0d",
                           got.kind, got.data, got.verb, got.opt);
            end
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      parse_rx_byte(b);
      sent_cnt++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (out_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic send_random_seq();
      int         r;
      int         n;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         b = 8'($urandom_range(0, 254));
         send_byte(b);
      end else if (r < 42) begin
         send_byte(T_IAC);
         send_byte(T_IAC);
      end else if (r < 70) begin
         send_byte(T_IAC);
         send_byte(8'($urandom_range(T_WILL, T_DONT)));
         n = $urandom_range(0, 9);
         if (n < 2)       send_byte(OPT_ECHO);
         else if (n < 4)  send_byte(OPT_SGA);
         else             send_byte(8'($urandom_range(0, 255)));
      end else if (r < 80) begin
         send_byte(T_IAC);
         send_byte(T_SB);
         n = $urandom_range(0, 6);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
               send_byte(T_IAC);
               b = 8'($urandom_range(0, 255));
               if (b == T_SE) b = T_IAC;
               send_byte(b);
            end else begin
               send_byte(8'($urandom_range(0, 254)));
            end
         end
         send_byte(T_IAC);
         send_byte(T_SE);
      end else if (r < 88) begin
         send_byte(T_IAC);
         send_byte(8'($urandom_range(0, 249)));
      end else begin
         // noise, broken or truncated sequences
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_directed();
      logic [7:0] seq[$];
      seq = '{8'h00, 8'h7f, 8'h80, T_DONT, T_WILL,
              T_IAC, T_IAC,
              T_IAC, T_WILL, OPT_ECHO,
              T_IAC, T_WILL, OPT_SGA,
              T_IAC, T_WILL, 8'h00,
              T_IAC, T_DO, OPT_SGA,
              T_IAC, T_DO, OPT_ECHO,
              T_IAC, T_WONT, 8'hff,
              T_IAC, T_DONT, 8'h00,
              T_IAC, 8'hf1,
              T_IAC, T_SE,
              T_IAC, T_SB, 8'h18, T_IAC, 8'h01, T_IAC, T_IAC, 8'hff, T_IAC, T_SE,
              8'h41};
      foreach (seq[i]) send_byte(seq[i]);
      wait_drained();
   endtask

   task automatic test_random();
      int target;
      target = sent_cnt + N_RANDOM;
      while (sent_cnt < target) begin
         if (sent_cnt % 200 < 30) idle_on = 1'b0;
         else                     idle_on = 1'b1;
         send_random_seq();
      end
      idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_backpressure();
      int target;
      hold_len = 400;
      target = sent_cnt + 80;
      idle_on = 1'b0;
      while (sent_cnt < target) send_random_seq();
      idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_pause();
      int k;
      for (k = 0; k < 4; k++) begin
         repeat (10) send_random_seq();
         wait_drained();
      end
   endtask

   initial begin
      mdl_state = ST_DATA;
      mdl_verb  = 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_pause();
      test_random();
      req_tvalid <= 1'b0;
      while (out_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_cnt == 0 && out_q.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
